// ===== design/tspp_pkg.sv =====
// Shared types, constants and helpers for the track segment polar parameter block.
// Used by the channel interfaces, the CORDIC and divider pipelines and the top level.
package tspp_pkg;

	localparam int COORD_BITS   = 24;
	localparam int ANGLE_BITS   = 16;
	localparam int DIFF_BITS    = COORD_BITS + 1;
	localparam int WW           = 64;
	localparam int SH_BITS      = 6;
	localparam int NORM_TOP     = 56;
	localparam int CORDIC_STEPS = 30;
	localparam int QUO_BITS     = 28;
	localparam int NUM_BITS     = DIFF_BITS + WW;
	localparam int MSH_BITS     = NUM_BITS + NORM_TOP + 1;
	localparam int REM_BITS     = 96;
	localparam int CORR_BITS    = COORD_BITS + 2;

	localparam logic [31:0] HALF_TURN  = 32'h8000_0000;
	localparam logic [31:0] TURN_3_4   = 32'hC000_0000;
	localparam logic [31:0] INV_GAIN   = 32'd2608131496;
	localparam logic signed [47:0] GUARD_COT = 48'sd100000;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_SAT = 2'd1;
	localparam logic [1:0] ST_DEG = 2'd2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [DIFF_BITS-1:0]  diff_t;
	typedef logic [ANGLE_BITS-1:0]        angle_t;

	localparam coord_t CRD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam coord_t CRD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [WW-1:0] C_HI = WW'(CRD_MAX);
	localparam logic signed [WW-1:0] C_LO = WW'(CRD_MIN);
	localparam logic [CORR_BITS-1:0] CORR_LIM = CORR_BITS'(1) << (COORD_BITS + 1);
	localparam angle_t ANG_ONE  = angle_t'(1);
	localparam angle_t ANG_HALF = angle_t'(1) << (ANGLE_BITS - 1);

	localparam logic [31:0] ATAN_TAB [0:CORDIC_STEPS-1] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
		32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1
	};

	typedef struct packed {
		coord_t target_x;
		coord_t target_y;
		coord_t target_z;
		coord_t cluster_x;
		coord_t cluster_y;
		coord_t cluster_z;
	} req_t;

	typedef struct packed {
		angle_t                   polar_angle;
		logic signed [ANGLE_BITS-1:0] azimuth;
		coord_t                   closest_z;
		coord_t                   radial_offset;
		logic [1:0]               status;
	} rsp_t;

	typedef struct packed {
		logic signed [WW-1:0] a;
		logic signed [WW-1:0] b;
		logic signed [WW-1:0] c;
		logic signed [WW-1:0] d;
		logic [31:0]          z;
	} vec_t;

	typedef struct packed {
		logic                 spec;
		angle_t               sp_polar;
		coord_t               sp_zm;
		coord_t               sp_r0;
		logic [1:0]           sp_status;
		logic [SH_BITS-1:0]   s1;
		logic [SH_BITS-1:0]   st;
		logic [DIFF_BITS-1:0] xz;
		logic                 dz_neg;
		logic                 dz_zero;
		logic                 t0;
		coord_t               tz;
		angle_t               azim;
		logic                 c_neg;
		logic                 c_zero;
		coord_t               r0;
		logic                 r0_sat;
	} side_t;

	typedef struct packed {
		coord_t v;
		logic   sat;
	} csat_t;

	function automatic logic [SH_BITS-1:0] bit_len(input logic [DIFF_BITS-1:0] v);
		logic [SH_BITS-1:0] r;
		r = '0;
		for (int i = 0; i < DIFF_BITS; i++) begin
			if (v[i]) r = SH_BITS'(i + 1);
		end
		return r;
	endfunction

	function automatic csat_t sat_coord(input logic signed [WW-1:0] v);
		csat_t r;
		r.v = COORD_BITS'(v);
		r.sat = 1'b0;
		if (v > C_HI) begin
			r.v = CRD_MAX;
			r.sat = 1'b1;
		end else if (v < C_LO) begin
			r.v = CRD_MIN;
			r.sat = 1'b1;
		end
		return r;
	endfunction

endpackage

// ===== design/tspp_req_if.sv =====
// Request channel: target and cluster point with valid/ready.
// Depends on tspp_pkg for the payload type.
interface tspp_req_if;
	logic          valid;
	logic          ready;
	tspp_pkg::req_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/tspp_rsp_if.sv =====
// Result channel: track angles, closest z, radial offset and status with valid/ready.
// Depends on tspp_pkg for the payload type.
interface tspp_rsp_if;
	logic          valid;
	logic          ready;
	tspp_pkg::rsp_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/track_segment_polar_params.sv =====
// Top level: straight-line track parameters from a target point and a cluster point.
// Uses tspp_pkg, tspp_req_if, tspp_rsp_if, tspp_cordic and tspp_div.
//
//   channel  dir  payload
//   req      in   target_x/y/z, cluster_x/y/z, 24 bit signed each
//   rsp      out  polar_angle, azimuth, closest_z, radial_offset, status
//
// One request per clock while the result register is not stalled.
// Depth is set by two 31-stage CORDIC pipelines in series, the second running beside
// a 31-stage one-bit-per-stage divider. Reset clears only the valid bits.
// All stages advance together while the result register is empty or being taken;
// a stalled result holds the whole pipe.
module track_segment_polar_params (
	input  logic       clk,
	input  logic       arst_n,
	tspp_req_if.sink   req,
	tspp_rsp_if.source rsp
);
	import tspp_pkg::*;

	logic en;
	assign en = !rsp.valid || rsp.ready;
	assign req.ready = en;

	// stage 1: differences
	logic   v_s1;
	coord_t tx_s1, ty_s1, tz_s1;
	diff_t  dx_s1, dy_s1, dz_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= req.valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tx_s1 <= req.data.target_x;
			ty_s1 <= req.data.target_y;
			tz_s1 <= req.data.target_z;
			dx_s1 <= DIFF_BITS'(req.data.cluster_x) - DIFF_BITS'(req.data.target_x);
			dy_s1 <= DIFF_BITS'(req.data.cluster_y) - DIFF_BITS'(req.data.target_y);
			dz_s1 <= DIFF_BITS'(req.data.cluster_z) - DIFF_BITS'(req.data.target_z);
		end
	end

	// stage 2: normalize, special tracks
	logic [DIFF_BITS-1:0] dx_m, dy_m, tx_m, ty_m, m_d, m_t;
	logic [SH_BITS-1:0]   s1_n, st_n;
	logic                 t0_n;
	logic signed [47:0]   gz;
	csat_t                gz_sat;
	vec_t                 vec_n;
	side_t                side_n;

	always_comb begin
		dx_m = dx_s1[DIFF_BITS-1] ? DIFF_BITS'(-dx_s1) : DIFF_BITS'(dx_s1);
		dy_m = dy_s1[DIFF_BITS-1] ? DIFF_BITS'(-dy_s1) : DIFF_BITS'(dy_s1);
		tx_m = tx_s1[COORD_BITS-1] ? -DIFF_BITS'(tx_s1) : DIFF_BITS'(tx_s1);
		ty_m = ty_s1[COORD_BITS-1] ? -DIFF_BITS'(ty_s1) : DIFF_BITS'(ty_s1);
		m_d = (dx_m > dy_m) ? dx_m : dy_m;
		m_t = (tx_m > ty_m) ? tx_m : ty_m;
		t0_n = (tx_s1 == '0) && (ty_s1 == '0);
		s1_n = SH_BITS'(NORM_TOP + 1) - bit_len(m_d);
		st_n = t0_n ? '0 : SH_BITS'(NORM_TOP + 1) - bit_len(m_t);

		vec_n.a = WW'(dx_s1) << s1_n;
		vec_n.b = WW'(dy_s1) << s1_n;
		vec_n.c = WW'(tx_s1) << st_n;
		vec_n.d = WW'(ty_s1) << st_n;
		vec_n.z = '0;

		gz = 48'(tz_s1) - 48'(tx_s1) * GUARD_COT;
		gz_sat = sat_coord(WW'(gz));

		side_n = '0;
		side_n.spec    = (dx_s1 == '0) && (dy_s1 == '0);
		side_n.s1      = s1_n;
		side_n.st      = st_n;
		side_n.xz      = dz_s1[DIFF_BITS-1] ? DIFF_BITS'(-dz_s1) : DIFF_BITS'(dz_s1);
		side_n.dz_neg  = dz_s1[DIFF_BITS-1];
		side_n.dz_zero = (dz_s1 == '0);
		side_n.t0      = t0_n;
		side_n.tz      = tz_s1;
		side_n.sp_polar  = ANG_ONE;
		side_n.sp_status = ST_OK;
		if (dz_s1 == '0) begin
			side_n.sp_status = ST_DEG;
		end else if (!dz_s1[DIFF_BITS-1]) begin
			side_n.sp_r0 = ty_s1;
			side_n.sp_zm = gz_sat.v;
			side_n.sp_status = gz_sat.sat ? ST_SAT : ST_OK;
		end else begin
			side_n.sp_r0 = ty_s1;
			side_n.sp_polar = ANG_HALF;
			if (tx_s1 == '0) begin
				side_n.sp_zm = tz_s1;
			end else begin
				side_n.sp_zm = tx_s1[COORD_BITS-1] ? CRD_MIN : CRD_MAX;
				side_n.sp_status = ST_SAT;
			end
		end
	end

	logic  v_s2;
	vec_t  vec_s2;
	side_t side_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s2  <= vec_n;
			side_s2 <= side_n;
		end
	end

	// azimuth CORDIC, target point rotated along
	logic  c1_valid;
	vec_t  c1_vec;
	side_t c1_side;

	tspp_cordic u_cordic_phi (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s2),
		.in_vec    (vec_s2),
		.in_side   (side_s2),
		.out_valid (c1_valid),
		.out_vec   (c1_vec),
		.out_side  (c1_side)
	);

	// stage 3: gain products
	logic [WW-1:0] ua, md, mc;
	side_t         side_m1;
	logic [31:0]   az_sum;

	always_comb begin
		ua = c1_vec.a;
		md = c1_vec.d[WW-1] ? WW'(-c1_vec.d) : WW'(c1_vec.d);
		mc = c1_vec.c[WW-1] ? WW'(-c1_vec.c) : WW'(c1_vec.c);
		az_sum = c1_vec.z + (32'd1 << (31 - ANGLE_BITS));
		side_m1 = c1_side;
		side_m1.azim   = az_sum[31:32-ANGLE_BITS];
		side_m1.c_neg  = c1_vec.c[WW-1];
		side_m1.c_zero = (c1_vec.c == '0);
	end

	logic              v_s3, d_neg_s3;
	side_t             side_s3;
	logic [WW-1:0]     den_s3, pa_lo_s3, pa_hi_s3, pd_lo_s3, pd_hi_s3;
	logic [DIFF_BITS+31:0] pn_lo_s3, pn_hi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (en) v_s3 <= c1_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3  <= side_m1;
			d_neg_s3 <= c1_vec.d[WW-1];
			den_s3   <= ua;
			pa_lo_s3 <= WW'(ua[31:0]) * WW'(INV_GAIN);
			pa_hi_s3 <= WW'(ua[WW-1:32]) * WW'(INV_GAIN);
			pd_lo_s3 <= WW'(md[31:0]) * WW'(INV_GAIN);
			pd_hi_s3 <= WW'(md[WW-1:32]) * WW'(INV_GAIN);
			pn_lo_s3 <= (DIFF_BITS+32)'(side_m1.xz) * (DIFF_BITS+32)'(mc[31:0]);
			pn_hi_s3 <= (DIFF_BITS+32)'(side_m1.xz) * (DIFF_BITS+32)'(mc[WW-1:32]);
		end
	end

	// stage 4: sum partial products, pick the rescale
	logic [SH_BITS-1:0] e_lim, e_n;

	always_comb begin
		e_lim = SH_BITS'(NORM_TOP + 2) - bit_len(side_s3.xz);
		e_n = (side_s3.s1 < e_lim) ? side_s3.s1 : e_lim;
	end

	logic                v_s4, d_neg_s4;
	side_t               side_s4;
	logic [WW-1:0]       den_s4, rho_s4;
	logic [95:0]         pd_s4;
	logic [NUM_BITS-1:0] num_s4;
	logic [SH_BITS-1:0]  e_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (en) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4  <= side_s3;
			d_neg_s4 <= d_neg_s3;
			den_s4   <= den_s3;
			e_s4     <= e_n;
			rho_s4   <= pa_hi_s3 + WW'(pa_lo_s3[WW-1:32]);
			pd_s4    <= {pd_hi_s3, 32'd0} + 96'(pd_lo_s3);
			num_s4   <= {pn_hi_s3, 32'd0} + NUM_BITS'(pn_lo_s3);
		end
	end

	// stage 5: radial offset, polar CORDIC operands
	logic [127:0]         pw, w;
	logic [WW-1:0]        rm;
	logic signed [WW-1:0] r0v, dz64;
	csat_t                r0_sat;
	side_t                side_m3;
	vec_t                 vec_m3;

	always_comb begin
		pw = 128'(pd_s4) + (128'd1 << (7'd31 + 7'(side_s4.st)));
		w  = pw >> (7'd32 + 7'(side_s4.st));
		rm = (w > 128'(CORR_LIM)) ? WW'(CORR_LIM) : WW'(w);
		r0v = d_neg_s4 ? -$signed(rm) : $signed(rm);
		r0_sat = sat_coord(r0v);
		side_m3 = side_s4;
		side_m3.r0 = r0_sat.v;
		side_m3.r0_sat = r0_sat.sat;
		dz64 = side_s4.dz_neg ? -$signed(WW'(side_s4.xz)) : $signed(WW'(side_s4.xz));
		vec_m3.a = dz64 << e_s4;
		vec_m3.b = rho_s4 >> (side_s4.s1 - e_s4);
		vec_m3.c = '0;
		vec_m3.d = '0;
		vec_m3.z = '0;
	end

	logic                v_s5;
	side_t               side_s5;
	vec_t                vec_s5;
	logic [WW-1:0]       den_s5;
	logic [NUM_BITS-1:0] num_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (en) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s5 <= side_m3;
			vec_s5  <= vec_m3;
			den_s5  <= den_s4;
			num_s5  <= num_s4;
		end
	end

	// polar CORDIC beside the closest-approach divider
	logic                 c2_valid;
	vec_t                 c2_vec;
	side_t                c2_side;
	logic [CORR_BITS-1:0] corr;

	tspp_cordic u_cordic_theta (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s5),
		.in_vec    (vec_s5),
		.in_side   (side_s5),
		.out_valid (c2_valid),
		.out_vec   (c2_vec),
		.out_side  (c2_side)
	);

	tspp_div u_div (
		.clk  (clk),
		.en   (en),
		.num  (num_s5),
		.den  (den_s5),
		.s1   (side_s5.s1),
		.st   (side_s5.st),
		.corr (corr)
	);

	// result stage
	logic [31:0]          pz;
	logic [32:0]          p_sum;
	angle_t               polar_n;
	logic signed [WW-1:0] zsum;
	csat_t                zm_sat;
	rsp_t                 rsp_n;

	always_comb begin
		if (c2_vec.z > TURN_3_4) pz = '0;
		else if (c2_vec.z > HALF_TURN) pz = HALF_TURN;
		else pz = c2_vec.z;
		p_sum = 33'(pz) + (33'd1 << (31 - ANGLE_BITS));
		polar_n = p_sum[31:32-ANGLE_BITS];
		if (polar_n == '0) polar_n = ANG_ONE;

		if (c2_side.dz_neg != c2_side.c_neg) zsum = WW'(c2_side.tz) + $signed(WW'(corr));
		else zsum = WW'(c2_side.tz) - $signed(WW'(corr));
		zm_sat = sat_coord(zsum);

		rsp_n.polar_angle = polar_n;
		rsp_n.azimuth     = c2_side.azim;
		if (c2_side.spec) begin
			rsp_n.polar_angle   = c2_side.sp_polar;
			rsp_n.azimuth       = '0;
			rsp_n.closest_z     = c2_side.sp_zm;
			rsp_n.radial_offset = c2_side.sp_r0;
			rsp_n.status        = c2_side.sp_status;
		end else if (c2_side.t0) begin
			rsp_n.closest_z     = c2_side.tz;
			rsp_n.radial_offset = '0;
			rsp_n.status        = ST_OK;
		end else if (c2_side.dz_zero || c2_side.c_zero) begin
			rsp_n.closest_z     = c2_side.tz;
			rsp_n.radial_offset = c2_side.r0;
			rsp_n.status        = c2_side.r0_sat ? ST_SAT : ST_OK;
		end else begin
			rsp_n.closest_z     = zm_sat.v;
			rsp_n.radial_offset = c2_side.r0;
			rsp_n.status        = (c2_side.r0_sat || zm_sat.sat) ? ST_SAT : ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp.valid <= 1'b0;
		else if (en) rsp.valid <= c2_valid;
	end

	always_ff @(posedge clk) begin
		if (en) rsp.data <= rsp_n;
	end

	a_stall_holds_req : assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |-> !req.ready)
		else $error("request taken while result stalled");

	a_polar_nonzero : assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.data.polar_angle != '0 && rsp.data.status != 2'd3)
		else $error("bad polar angle or status code");

	a_deg_zero : assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_DEG |->
		rsp.data.azimuth == '0 && rsp.data.closest_z == '0 && rsp.data.radial_offset == '0)
		else $error("identical points give nonzero result");

	a_sat_rail : assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.data.status == ST_SAT |->
		rsp.data.closest_z == CRD_MAX || rsp.data.closest_z == CRD_MIN ||
		rsp.data.radial_offset == CRD_MAX || rsp.data.radial_offset == CRD_MIN)
		else $error("saturation reported without a rail value");

endmodule

// ===== design/tspp_cordic.sv =====
// Pipelined vectoring CORDIC: one half-plane stage, then one micro-rotation per stage.
// (c, d) follow the rotations of (a, b); a side record travels along. Uses tspp_pkg.
module tspp_cordic (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  tspp_pkg::vec_t  in_vec,
	input  tspp_pkg::side_t in_side,
	output logic          out_valid,
	output tspp_pkg::vec_t  out_vec,
	output tspp_pkg::side_t out_side
);
	import tspp_pkg::*;

	vec_t  vec_s   [0:CORDIC_STEPS];
	side_t side_s  [0:CORDIC_STEPS];
	logic  valid_s [0:CORDIC_STEPS];
	vec_t  pre;

	always_comb begin
		pre = in_vec;
		pre.z = '0;
		if (in_vec.a[WW-1]) begin
			pre.a = -in_vec.a;
			pre.b = -in_vec.b;
			pre.c = -in_vec.c;
			pre.d = -in_vec.d;
			pre.z = HALF_TURN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s[0] <= 1'b0;
		else if (en) valid_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			vec_s[0]  <= pre;
			side_s[0] <= in_side;
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		logic signed [WW-1:0] a, b, c, d;
		vec_t nxt;

		assign a = vec_s[i].a;
		assign b = vec_s[i].b;
		assign c = vec_s[i].c;
		assign d = vec_s[i].d;

		always_comb begin
			if (!b[WW-1]) begin
				nxt.a = a + (b >>> i);
				nxt.b = b - (a >>> i);
				nxt.c = c + (d >>> i);
				nxt.d = d - (c >>> i);
				nxt.z = vec_s[i].z + ATAN_TAB[i];
			end else begin
				nxt.a = a - (b >>> i);
				nxt.b = b + (a >>> i);
				nxt.c = c - (d >>> i);
				nxt.d = d + (c >>> i);
				nxt.z = vec_s[i].z - ATAN_TAB[i];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s[i+1] <= 1'b0;
			else if (en) valid_s[i+1] <= valid_s[i];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				vec_s[i+1]  <= nxt;
				side_s[i+1] <= side_s[i];
			end
		end
	end

	assign out_valid = valid_s[CORDIC_STEPS];
	assign out_vec   = vec_s[CORDIC_STEPS];
	assign out_side  = side_s[CORDIC_STEPS];

endmodule

// ===== design/tspp_div.sv =====
// Pipelined restoring divider for the closest-approach correction, one quotient bit a stage.
// Scales the numerator, checks overflow, rounds when st is nonzero and limits the result. Uses tspp_pkg.
module tspp_div (
	input  logic                           clk,
	input  logic                           en,
	input  logic [tspp_pkg::NUM_BITS-1:0]  num,
	input  logic [tspp_pkg::WW-1:0]        den,
	input  logic [tspp_pkg::SH_BITS-1:0]   s1,
	input  logic [tspp_pkg::SH_BITS-1:0]   st,
	output logic [tspp_pkg::CORR_BITS-1:0] corr
);
	import tspp_pkg::*;

	logic signed [7:0]     lsh;
	logic [7:0]            nsh;
	logic [MSH_BITS-1:0]   mw;
	logic [MSH_BITS-1:0]   m_s1;
	logic [WW-1:0]         den_s1;
	logic                  rnd_s1;

	logic [REM_BITS-1:0]   rem_s [0:QUO_BITS];
	logic [QUO_BITS-1:0]   quo_s [0:QUO_BITS];
	logic [WW-1:0]         den_s [0:QUO_BITS];
	logic                  ovf_s [0:QUO_BITS];
	logic                  rnd_s [0:QUO_BITS];

	logic [QUO_BITS:0]     yr;
	logic [CORR_BITS-1:0]  cn;
	logic [CORR_BITS-1:0]  corr_s;

	always_comb begin
		lsh = $signed({2'b00, s1}) + 8'sd1 - $signed({2'b00, st});
		nsh = 8'(-lsh);
		if (st == '0) mw = MSH_BITS'(num) << s1;
		else if (!lsh[7]) mw = MSH_BITS'(num) << lsh[SH_BITS-1:0];
		else mw = MSH_BITS'(num) >> nsh[SH_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= mw;
			den_s1 <= den;
			rnd_s1 <= (st != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= m_s1[REM_BITS-1:0];
			quo_s[0] <= '0;
			den_s[0] <= den_s1;
			ovf_s[0] <= (m_s1[MSH_BITS-1:QUO_BITS] >= (MSH_BITS-QUO_BITS)'(den_s1));
			rnd_s[0] <= rnd_s1;
		end
	end

	for (genvar j = 0; j < QUO_BITS; j++) begin : g_bit
		logic [REM_BITS-1:0] sub;
		logic                ge;

		assign sub = REM_BITS'(den_s[j]) << (QUO_BITS - 1 - j);
		assign ge  = (rem_s[j] >= sub);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[j+1] <= ge ? rem_s[j] - sub : rem_s[j];
				quo_s[j+1] <= {quo_s[j][QUO_BITS-2:0], ge};
				den_s[j+1] <= den_s[j];
				ovf_s[j+1] <= ovf_s[j];
				rnd_s[j+1] <= rnd_s[j];
			end
		end
	end

	always_comb begin
		if (rnd_s[QUO_BITS]) yr = ((QUO_BITS+1)'(quo_s[QUO_BITS]) + 1'b1) >> 1;
		else yr = (QUO_BITS+1)'(quo_s[QUO_BITS]);
		if (ovf_s[QUO_BITS] || (yr > (QUO_BITS+1)'(CORR_LIM))) cn = CORR_LIM;
		else cn = CORR_BITS'(yr);
	end

	always_ff @(posedge clk) begin
		if (en) corr_s <= cn;
	end

	assign corr = corr_s;

endmodule
